// File: rtl/core/slfp_pkg.sv
package slfp_pkg;

    localparam int LINE_BYTES        = 64;
    localparam int HOTKEY_TEXT_BYTES = 64;

    localparam int ADDR_W = (LINE_BYTES > 1) ? $clog2(LINE_BYTES) : 1;
    localparam int FILL_W = $clog2(LINE_BYTES + 1);

    localparam logic [3:0] KIND_HOTKEY    = 4'd0;
    localparam logic [3:0] KIND_BEGIN     = 4'd1;
    localparam logic [3:0] KIND_LOCKED    = 4'd2;
    localparam logic [3:0] KIND_ABORTED   = 4'd3;
    localparam logic [3:0] KIND_END       = 4'd4;
    localparam logic [3:0] KIND_TIMEOUT   = 4'd5;
    localparam logic [3:0] KIND_COMMAND   = 4'd6;
    localparam logic [3:0] KIND_UNKNOWN   = 4'd7;
    localparam logic [3:0] KIND_MALFORMED = 4'd8;

    localparam logic [7:0] CHAR_H  = 8'h48;
    localparam logic [7:0] CHAR_B  = 8'h42;
    localparam logic [7:0] CHAR_L  = 8'h4C;
    localparam logic [7:0] CHAR_A  = 8'h41;
    localparam logic [7:0] CHAR_E  = 8'h45;
    localparam logic [7:0] CHAR_T  = 8'h54;
    localparam logic [7:0] CHAR_C  = 8'h43;
    localparam logic [7:0] CHAR_NL = 8'h0A;
    localparam logic [7:0] CHAR_NUL = 8'h00;

    typedef struct packed {
        logic       store_byte;
        logic       clear_line;
        logic       load_single;
        logic [3:0] single_kind;
        logic       start_text;
        logic       read_text;
        logic       load_text;
    } slfp_cmd_t;

    typedef struct packed {
        logic       is_newline;
        logic       store_full;
        logic       line_bad;
        logic       text_too_long;
        logic       text_empty;
        logic       idx_last;
        logic       out_free;
        logic [3:0] prefix_kind;
    } slfp_sts_t;

    function automatic logic [3:0] prefix_to_kind(input logic [7:0] b);
        logic [3:0] k;
        case (b)
            CHAR_H:  k = KIND_HOTKEY;
            CHAR_B:  k = KIND_BEGIN;
            CHAR_L:  k = KIND_LOCKED;
            CHAR_A:  k = KIND_ABORTED;
            CHAR_E:  k = KIND_END;
            CHAR_T:  k = KIND_TIMEOUT;
            CHAR_C:  k = KIND_COMMAND;
            default: k = KIND_UNKNOWN;
        endcase
        return k;
    endfunction

endpackage

// File: rtl/core/slfp_ram.sv
module slfp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                  clk,
    input  logic                                  we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                      wdata,
    input  logic                                  re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                      rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/core/slfp_ctrl.sv
module slfp_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  slfp_pkg::slfp_sts_t sts,
    output slfp_pkg::slfp_cmd_t cmd
);
    import slfp_pkg::*;

    localparam logic [1:0] S_COLLECT = 2'd0;
    localparam logic [1:0] S_DISCARD = 2'd1;
    localparam logic [1:0] S_READ    = 2'd2;
    localparam logic [1:0] S_LOAD    = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       in_fire;

    assign in_stall = (state_reg inside {S_READ, S_LOAD}) || !sts.out_free;
    assign in_fire  = in_valid && !in_stall;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_COLLECT:
            begin
                if (in_fire)
                begin
                    if (sts.is_newline)
                    begin
                        if (sts.line_bad)
                        begin
                            cmd.load_single = 1'b1;
                            cmd.single_kind = KIND_MALFORMED;
                            cmd.clear_line  = 1'b1;
                        end
                        else if (sts.prefix_kind == KIND_HOTKEY)
                        begin
                            if (sts.text_too_long)
                            begin
                                cmd.load_single = 1'b1;
                                cmd.single_kind = KIND_MALFORMED;
                                cmd.clear_line  = 1'b1;
                            end
                            else if (sts.text_empty)
                            begin
                                cmd.load_single = 1'b1;
                                cmd.single_kind = KIND_HOTKEY;
                                cmd.clear_line  = 1'b1;
                            end
                            else
                            begin
                                cmd.start_text = 1'b1;
                                state_next     = S_READ;
                            end
                        end
                        else
                        begin
                            cmd.load_single = 1'b1;
                            cmd.single_kind = sts.prefix_kind;
                            cmd.clear_line  = 1'b1;
                        end
                    end
                    else if (sts.store_full)
                    begin
                        cmd.load_single = 1'b1;
                        cmd.single_kind = KIND_MALFORMED;
                        cmd.clear_line  = 1'b1;
                        state_next      = S_DISCARD;
                    end
                    else
                    begin
                        cmd.store_byte = 1'b1;
                    end
                end
            end
            S_DISCARD:
            begin
                if (in_fire && sts.is_newline)
                begin
                    state_next = S_COLLECT;
                end
            end
            S_READ:
            begin
                cmd.read_text = 1'b1;
                state_next    = S_LOAD;
            end
            S_LOAD:
            begin
                if (sts.out_free)
                begin
                    cmd.load_text = 1'b1;
                    if (sts.idx_last)
                    begin
                        cmd.clear_line = 1'b1;
                        state_next     = S_COLLECT;
                    end
                    else
                    begin
                        state_next = S_READ;
                    end
                end
            end
            default:
            begin
                state_next = S_COLLECT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_COLLECT;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: rtl/core/slfp_dp.sv
module slfp_dp (
    input  logic              clk,
    input  logic              rst_n,
    input  logic [7:0]        in_byte,
    input  slfp_pkg::slfp_cmd_t cmd,
    output slfp_pkg::slfp_sts_t sts,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [3:0]        kind,
    output logic [7:0]        prefix_byte,
    output logic [7:0]        text_byte,
    output logic              text_valid,
    output logic              last
);
    import slfp_pkg::*;

    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;
    logic              nul_reg;
    logic              nul_next;
    logic [7:0]        prefix_reg;
    logic [ADDR_W-1:0] idx_reg;
    logic [ADDR_W-1:0] idx_next;
    logic [7:0]        ram_rdata;

    logic              out_valid_reg;
    logic              out_valid_next;
    logic [3:0]        kind_reg;
    logic [7:0]        prefix_out_reg;
    logic [7:0]        text_reg;
    logic              text_valid_reg;
    logic              last_reg;

    slfp_ram #(
        .WIDTH (8),
        .DEPTH (LINE_BYTES)
    ) u_line_store (
        .clk   (clk),
        .we    (cmd.store_byte),
        .waddr (fill_reg[ADDR_W-1:0]),
        .wdata (in_byte),
        .re    (cmd.read_text),
        .raddr (idx_reg),
        .rdata (ram_rdata)
    );

    assign sts.is_newline    = (in_byte == CHAR_NL);
    assign sts.store_full    = (int'(fill_reg) >= LINE_BYTES);
    assign sts.line_bad      = (fill_reg == '0) || nul_reg;
    assign sts.text_too_long = (int'(fill_reg) > HOTKEY_TEXT_BYTES);
    assign sts.text_empty    = (fill_reg == FILL_W'(1));
    assign sts.idx_last      = ((FILL_W'(idx_reg) + FILL_W'(1)) == fill_reg);
    assign sts.out_free      = !out_valid_reg || !out_stall;
    assign sts.prefix_kind   = prefix_to_kind(prefix_reg);

    always_comb
    begin
        fill_next = fill_reg;
        nul_next  = nul_reg;
        idx_next  = idx_reg;
        if (cmd.clear_line)
        begin
            fill_next = '0;
            nul_next  = 1'b0;
        end
        else if (cmd.store_byte)
        begin
            fill_next = fill_reg + FILL_W'(1);
            if (in_byte == CHAR_NUL)
            begin
                nul_next = 1'b1;
            end
        end
        if (cmd.start_text)
        begin
            idx_next = ADDR_W'(1);
        end
        else if (cmd.load_text)
        begin
            idx_next = idx_reg + ADDR_W'(1);
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.load_single || cmd.load_text)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg      <= '0;
            nul_reg       <= 1'b0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            fill_reg      <= fill_next;
            nul_reg       <= nul_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.store_byte && (fill_reg == '0))
        begin
            prefix_reg <= in_byte;
        end
        if (cmd.load_single)
        begin
            kind_reg       <= cmd.single_kind;
            prefix_out_reg <= (cmd.single_kind == KIND_UNKNOWN) ? prefix_reg : 8'd0;
            text_reg       <= 8'd0;
            text_valid_reg <= 1'b0;
            last_reg       <= 1'b1;
        end
        else if (cmd.load_text)
        begin
            kind_reg       <= KIND_HOTKEY;
            prefix_out_reg <= 8'd0;
            text_reg       <= ram_rdata;
            text_valid_reg <= 1'b1;
            last_reg       <= sts.idx_last;
        end
    end

    assign out_valid   = out_valid_reg;
    assign kind        = kind_reg;
    assign prefix_byte = prefix_out_reg;
    assign text_byte   = text_reg;
    assign text_valid  = text_valid_reg;
    assign last        = last_reg;

endmodule

// File: rtl/core/status_line_framer_parser_unit.sv
// Status line framer and parser. Bytes arrive on in_byte and are taken one per cycle while
// a line is collected or dropped; in_stall rises only while a finished result waits in the
// output register and is not taken, and while hotkey text is sent. A newline turns the held
// line into one message: a single result for every kind, or one result per hotkey text byte
// with last on the final one when a hotkey line holds text. Each text byte is read from the
// line store in the read state, a registered read, then loaded into the output register in
// the load state, which waits while a result is held. A byte that finds the store full gives
// malformed at once, and bytes up to and including the next newline are then dropped without result.
module status_line_framer_parser_unit (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [3:0] kind,
    output logic [7:0] prefix_byte,
    output logic [7:0] text_byte,
    output logic       text_valid,
    output logic       last
);
    import slfp_pkg::*;

    slfp_cmd_t cmd;
    slfp_sts_t sts;

    slfp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_valid),
        .in_stall (in_stall),
        .sts      (sts),
        .cmd      (cmd)
    );

    slfp_dp u_dp (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_byte     (in_byte),
        .cmd         (cmd),
        .sts         (sts),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .prefix_byte (prefix_byte),
        .text_byte   (text_byte),
        .text_valid  (text_valid),
        .last        (last)
    );

endmodule

// File: rtl/core/slfp_checker.sv
module slfp_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_stall,
    input logic [7:0] in_byte,
    input logic       out_valid,
    input logic       out_stall,
    input logic [3:0] kind,
    input logic [7:0] prefix_byte,
    input logic [7:0] text_byte,
    input logic       text_valid,
    input logic       last
);
    import slfp_pkg::*;

    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_stall |=> in_valid && $stable(in_byte))
        else $error("stalled input transfer changed");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(kind) && $stable(prefix_byte)
            && $stable(text_byte) && $stable(text_valid) && $stable(last))
        else $error("stalled result dropped or changed");

    a_text_hotkey: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && text_valid |-> kind == KIND_HOTKEY)
        else $error("text byte on a non-hotkey result");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_HOTKEY |-> last)
        else $error("non-hotkey result without last");

    a_prefix_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && kind != KIND_UNKNOWN |-> prefix_byte == 8'd0)
        else $error("prefix byte set on a known kind");

endmodule

bind status_line_framer_parser_unit slfp_checker u_slfp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_byte     (in_byte),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .kind        (kind),
    .prefix_byte (prefix_byte),
    .text_byte   (text_byte),
    .text_valid  (text_valid),
    .last        (last)
);

// File: tb/status_line_framer_parser_unit_tb.sv
module status_line_framer_parser_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import slfp_pkg::*;

    localparam int HOLD_FOR_IDLE = -1;
    localparam int MAX_WAIT      = 13;
    localparam int RANDOM_BYTES  = 300;
    localparam int DRAIN_CYCLES  = 24;
    localparam int CYCLE_LIMIT   = 400000;

    typedef struct {
        logic [3:0] kind;
        logic [7:0] prefix;
        logic [7:0] text;
        logic       tvalid;
        logic       last;
    } status_result_t;

    typedef enum int {
        LINE_SINGLE,
        LINE_HOTKEY,
        LINE_UNKNOWN,
        LINE_NOISE,
        LINE_NUL,
        LINE_OVERFLOW,
        LINE_FULL
    } line_style_e;

    logic       clk;
    logic       rst_n;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       out_valid;
    logic       out_stall;
    logic [3:0] kind;
    logic [7:0] prefix_byte;
    logic [7:0] text_byte;
    logic       text_valid;
    logic       last;

    status_line_framer_parser_unit uut (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .in_byte     (in_byte),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .kind        (kind),
        .prefix_byte (prefix_byte),
        .text_byte   (text_byte),
        .text_valid  (text_valid),
        .last        (last)
    );

    int             byte_queue[$];
    status_result_t expected_msgs[$];

    logic [7:0] held_line[LINE_BYTES];
    int         held_count;
    bit         held_nul;
    bit         dropping;

    bit in_fire;
    bit out_fire;
    bit no_idle;
    int gap_left;
    int stall_left;
    int cycle_count;
    int mismatches;
    int bytes_sent;
    int lines_framed;
    int results_checked;
    int overflows;

    initial
    begin
        clk = 1'b0;
        forever #6 clk = ~clk;
    end

    function automatic int draw_wait();
        return no_idle ? 0 : $urandom_range(0, MAX_WAIT);
    endfunction

    function automatic int pick_text_byte();
        int b;
        do
            b = $urandom_range(0, 255);
        while (b == CHAR_NL || b == CHAR_NUL);
        return b;
    endfunction

    task automatic note_mismatch(input string what, input int got, input int want);
        $display("[%0t] mismatch %s: got %0d, expected %0d", $time, what, got, want);
        mismatches++;
    endtask

    task automatic add_byte(input int b);
        byte_queue.push_back(b);
        bytes_sent++;
    endtask

    task automatic add_line(input line_style_e style);
        int n;
        int pos;
        int singles[6];
        singles = '{CHAR_B, CHAR_L, CHAR_A, CHAR_E, CHAR_T, CHAR_C};
        case (style)
            LINE_SINGLE:
            begin
                add_byte(singles[$urandom_range(0, 5)]);
                n = $urandom_range(0, 5);
                repeat (n) add_byte(pick_text_byte());
                add_byte(CHAR_NL);
            end
            LINE_HOTKEY:
            begin
                add_byte(CHAR_H);
                n = $urandom_range(0, 12);
                repeat (n) add_byte(pick_text_byte());
                add_byte(CHAR_NL);
            end
            LINE_UNKNOWN:
            begin
                n = $urandom_range(1, 6);
                repeat (n) add_byte(pick_text_byte());
                add_byte(CHAR_NL);
            end
            LINE_NOISE:
            begin
                n = $urandom_range(1, 6);
                repeat (n) add_byte($urandom_range(0, 255));
            end
            LINE_NUL:
            begin
                n = $urandom_range(1, 6);
                pos = $urandom_range(0, n - 1);
                for (int i = 0; i < n; i++)
                    add_byte(i == pos ? CHAR_NUL : ($urandom_range(0, 1) ? CHAR_H
                                                                        : pick_text_byte()));
                add_byte(CHAR_NL);
            end
            LINE_OVERFLOW:
            begin
                n = LINE_BYTES + $urandom_range(1, 5);
                repeat (n) add_byte($urandom_range(0, 1) ? CHAR_NUL : pick_text_byte());
                add_byte(CHAR_NL);
            end
            default:
            begin
                add_byte($urandom_range(0, 3) != 0 ? CHAR_H : singles[$urandom_range(0, 5)]);
                n = $urandom_range(LINE_BYTES - 6, LINE_BYTES - 1);
                repeat (n) add_byte(pick_text_byte());
                add_byte(CHAR_NL);
            end
        endcase
    endtask

    task automatic parse_status_byte(input logic [7:0] b);
        status_result_t r;
        int text_len;
        r.kind   = KIND_MALFORMED;
        r.prefix = 8'h00;
        r.text   = 8'h00;
        r.tvalid = 1'b0;
        r.last   = 1'b1;
        if (dropping)
        begin
            if (b == CHAR_NL)
                dropping = 1'b0;
        end
        else if (b == CHAR_NL)
        begin
            lines_framed++;
            if (held_count == 0 || held_nul)
                expected_msgs.push_back(r);
            else if (held_line[0] == CHAR_H)
            begin
                text_len = held_count - 1;
                r.kind = KIND_HOTKEY;
                if (text_len >= HOTKEY_TEXT_BYTES)
                begin
                    r.kind = KIND_MALFORMED;
                    expected_msgs.push_back(r);
                end
                else if (text_len == 0)
                    expected_msgs.push_back(r);
                else
                    for (int i = 0; i < text_len; i++)
                    begin
                        r.text   = held_line[i + 1];
                        r.tvalid = 1'b1;
                        r.last   = (i == text_len - 1);
                        expected_msgs.push_back(r);
                    end
            end
            else
            begin
                case (held_line[0])
                    CHAR_B:  r.kind = KIND_BEGIN;
                    CHAR_L:  r.kind = KIND_LOCKED;
                    CHAR_A:  r.kind = KIND_ABORTED;
                    CHAR_E:  r.kind = KIND_END;
                    CHAR_T:  r.kind = KIND_TIMEOUT;
                    CHAR_C:  r.kind = KIND_COMMAND;
                    default:
                    begin
                        r.kind   = KIND_UNKNOWN;
                        r.prefix = held_line[0];
                    end
                endcase
                expected_msgs.push_back(r);
            end
            held_count = 0;
            held_nul   = 1'b0;
        end
        else if (held_count >= LINE_BYTES)
        begin
            overflows++;
            dropping   = 1'b1;
            held_count = 0;
            held_nul   = 1'b0;
            expected_msgs.push_back(r);
        end
        else
        begin
            held_line[held_count] = b;
            held_count++;
            if (b == CHAR_NUL)
                held_nul = 1'b1;
        end
    endtask

    task automatic check_result();
        status_result_t want;
        results_checked++;
        if (expected_msgs.size() == 0)
            note_mismatch("result with none pending, kind", int'(kind), -1);
        else
        begin
            want = expected_msgs.pop_front();
            if (kind !== want.kind)
                note_mismatch("kind", int'(kind), int'(want.kind));
            if (prefix_byte !== want.prefix)
                note_mismatch("prefix_byte", int'(prefix_byte), int'(want.prefix));
            if (text_byte !== want.text)
                note_mismatch("text_byte", int'(text_byte), int'(want.text));
            if (text_valid !== want.tvalid)
                note_mismatch("text_valid", int'(text_valid), int'(want.tvalid));
            if (last !== want.last)
                note_mismatch("last", int'(last), int'(want.last));
        end
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_fire  <= 1'b0;
            out_fire <= 1'b0;
        end
        else
        begin
            cycle_count++;
            if (cycle_count % 200 == 0)
                no_idle = ($urandom_range(0, 2) == 0);
            in_fire  <= in_valid && !in_stall;
            out_fire <= out_valid && !out_stall;
            if (in_valid && !in_stall)
                parse_status_byte(in_byte);
            if (out_valid && !out_stall)
                check_result();
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_fire))
        begin
            if (gap_left > 0)
            begin
                gap_left--;
                in_valid <= 1'b0;
            end
            else if (byte_queue.size() > 0 && byte_queue[0] == HOLD_FOR_IDLE)
            begin
                if (expected_msgs.size() == 0)
                    void'(byte_queue.pop_front());
                in_valid <= 1'b0;
            end
            else if (byte_queue.size() > 0)
            begin
                in_byte  <= 8'(byte_queue.pop_front());
                in_valid <= 1'b1;
                gap_left = draw_wait();
            end
            else
                in_valid <= 1'b0;
        end
    end

    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_fire)
                stall_left = draw_wait();
            if (stall_left > 0)
            begin
                stall_left--;
                out_stall <= 1'b1;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("timeout after %0d cycles", CYCLE_LIMIT);
        $display("status: fail");
        $finish;
    end

    initial
    begin
        int directed[$];
        int pick;
        bit paused;
        rst_n      = 1'b0;
        in_valid   = 1'b0;
        in_byte    = 8'h00;
        out_stall  = 1'b0;
        held_count = 0;
        held_nul   = 1'b0;
        dropping   = 1'b0;
        gap_left   = 0;
        stall_left = 0;
        no_idle    = 1'b0;
        paused     = 1'b0;

        directed = '{CHAR_NL,
                     CHAR_B, CHAR_NL, CHAR_L, CHAR_NL, CHAR_A, CHAR_NL,
                     CHAR_E, CHAR_NL, CHAR_T, CHAR_NL, CHAR_C, CHAR_NL,
                     CHAR_H, CHAR_NL,
                     CHAR_H, 8'hFF, CHAR_NL,
                     8'hFF, CHAR_NL,
                     CHAR_B, CHAR_NUL, CHAR_NL,
                     CHAR_H, 8'h61, 8'h80, CHAR_NL};
        foreach (directed[i])
            add_byte(directed[i]);
        byte_queue.push_back(HOLD_FOR_IDLE);

        add_line(LINE_FULL);
        add_line(LINE_OVERFLOW);
        while (bytes_sent < directed.size() + RANDOM_BYTES)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 40)
                add_line(LINE_SINGLE);
            else if (pick < 68)
                add_line(LINE_HOTKEY);
            else if (pick < 80)
                add_line(LINE_UNKNOWN);
            else if (pick < 88)
                add_line(LINE_NOISE);
            else if (pick < 95)
                add_line(LINE_NUL);
            else if (pick < 98)
                add_line(LINE_OVERFLOW);
            else
                add_line(LINE_FULL);
            if (!paused && bytes_sent > directed.size() + RANDOM_BYTES / 2)
            begin
                byte_queue.push_back(HOLD_FOR_IDLE);
                paused = 1'b1;
            end
        end
        add_line(LINE_SINGLE);

        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        do
            @(posedge clk);
        while (byte_queue.size() != 0 || in_valid || expected_msgs.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (expected_msgs.size() != 0)
            note_mismatch("results outstanding at end", 0, expected_msgs.size());
        $display("covered %0d bytes in %0d framed lines, %0d store overflows",
                 bytes_sent, lines_framed, overflows);
        $display("compared %0d results over %0d cycles, %0d mismatches",
                 results_checked, cycle_count, mismatches);
        if (mismatches == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// File: status_line_framer_parser_unit.f
rtl/core/slfp_pkg.sv
rtl/core/slfp_ram.sv
rtl/core/slfp_ctrl.sv
rtl/core/slfp_dp.sv
rtl/core/status_line_framer_parser_unit.sv
rtl/core/slfp_checker.sv
tb/status_line_framer_parser_unit_tb.sv
